// ===== src/lesp_pkg.sv =====
// lesp_pkg: shared types and constants for the line edge point stepper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lesp_pkg;

   // action codes carried in the request word
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // screen height register
   localparam int unsigned HEIGHT_W = 15;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 15'd480;

   // depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // queue status seen by the back end
   typedef struct packed {
      logic not_empty;
      logic full;
   } lesp_qstat_type;

endpackage

`default_nettype wire

// ===== src/lesp_front.sv =====
// lesp_front: takes request words, forms deltas and step signs, packs a queue entry
// depends on lesp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lesp_front
   import lesp_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int TAG_BITS   = 16,
   parameter int ENTRY_W    = 3 + 4 * COORD_BITS + 2 * TAG_BITS
) (
   input  wire logic                         req_action,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic        [TAG_BITS-1:0]   req_first_tag,
   input  wire logic        [TAG_BITS-1:0]   req_second_tag,
   output      logic        [ENTRY_W-1:0]    q_data
);

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic        [COORD_BITS:0] dx_abs;
   logic        [COORD_BITS:0] dy_abs;

   // signed deltas, one bit wider than a coordinate
   assign dx = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
   assign dy = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};

   // magnitudes; they always fit in an unsigned coordinate width
   assign dx_abs = dx[COORD_BITS] ? -dx : dx;
   assign dy_abs = dy[COORD_BITS] ? -dy : dy;

   // queue word: action, sign bits, start point, magnitudes, tags
   assign q_data = {req_action, dx[COORD_BITS], dy[COORD_BITS], req_start_x, req_start_y,
                    dx_abs[COORD_BITS-1:0], dy_abs[COORD_BITS-1:0],
                    req_first_tag, req_second_tag};

endmodule

`default_nettype wire

// ===== src/lesp_fifo.sv =====
// lesp_fifo: short register queue between the front and back ends
// depends on lesp_pkg (depth and status struct)
`timescale 1ns / 1ps
`default_nettype none

module lesp_fifo
   import lesp_pkg::*;
#(
   parameter int WIDTH = 99
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] head_data,
   output      lesp_qstat_type   stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == CNT_FULL);
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign head_data      = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill count stays within the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL) else $error("queue count beyond depth");

   // a push while full never lands
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (stat.full && !pop) |=> stat.full && $stable(wr_ptr_ff))
      else $error("queue overwritten while full");

endmodule

`default_nettype wire

// ===== src/lesp_back.sv =====
// lesp_back: edge state, bresenham step and result register
// depends on lesp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lesp_back
   import lesp_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int TAG_BITS   = 16,
   parameter int ENTRY_W    = 3 + 4 * COORD_BITS + 2 * TAG_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic        [ENTRY_W-1:0]    q_data,
   input  wire lesp_qstat_type               q_stat,
   output      logic                         q_pop,
   input  wire logic        [HEIGHT_W-1:0]   screen_height,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic                         rsp_has_point,
   output      logic signed [COORD_BITS-1:0] rsp_point_x,
   output      logic signed [COORD_BITS-1:0] rsp_point_y,
   output      logic                         rsp_in_range,
   output      logic                         rsp_is_last,
   output      logic        [TAG_BITS-1:0]   rsp_tag_a,
   output      logic        [TAG_BITS-1:0]   rsp_tag_b
);

   localparam int ERR_W = COORD_BITS + 3;
   localparam int CMP_W = ((COORD_BITS > HEIGHT_W) ? COORD_BITS : HEIGHT_W) + 1;

   // unpacked queue word
   logic                  e_action;
   logic                  e_sx_neg;
   logic                  e_sy_neg;
   logic [COORD_BITS-1:0] e_x0;
   logic [COORD_BITS-1:0] e_y0;
   logic [COORD_BITS-1:0] e_adx;
   logic [COORD_BITS-1:0] e_ady;
   logic [TAG_BITS-1:0]   e_tag_a;
   logic [TAG_BITS-1:0]   e_tag_b;

   // edge state
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [ERR_W-1:0]      inc_diag_ff, inc_diag_in;
   logic signed [ERR_W-1:0]      inc_straight_ff, inc_straight_in;
   logic                         sx_neg_ff, sx_neg_in;
   logic                         sy_neg_ff, sy_neg_in;
   logic                         major_x_ff, major_x_in;
   logic [COORD_BITS-1:0]        left_ff, left_in;
   logic [TAG_BITS-1:0]          tag_a_ff, tag_a_in;
   logic [TAG_BITS-1:0]          tag_b_ff, tag_b_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         has_point_ff, has_point_in;
   logic signed [COORD_BITS-1:0] point_x_ff, point_x_in;
   logic signed [COORD_BITS-1:0] point_y_ff, point_y_in;
   logic                         in_range_ff, in_range_in;
   logic                         is_last_ff, is_last_in;
   logic [TAG_BITS-1:0]          out_tag_a_ff, out_tag_a_in;
   logic [TAG_BITS-1:0]          out_tag_b_ff, out_tag_b_in;

   // start set-up values
   logic                  st_major_x;
   logic [COORD_BITS-1:0] st_major;
   logic [COORD_BITS-1:0] st_minor;
   logic [ERR_W-1:0]      st_minor2;
   logic [ERR_W-1:0]      st_major2;
   logic [ERR_W-1:0]      st_major1;

   // step values
   logic                         err_pos;
   logic                         move_x;
   logic                         move_y;
   logic signed [COORD_BITS-1:0] step_x;
   logic signed [COORD_BITS-1:0] step_y;
   logic signed [CMP_W-1:0]      cy_ext;
   logic signed [CMP_W-1:0]      h_ext;
   logic                         y_in_range;

   assign {e_action, e_sx_neg, e_sy_neg, e_x0, e_y0, e_adx, e_ady, e_tag_a, e_tag_b} = q_data;

   // take a word whenever the result register is free or being emptied
   assign q_pop = q_stat.not_empty && (!rsp_valid_ff || !rsp_stall);

   // start: pick the major axis and form the increments
   assign st_major_x = (e_ady < e_adx);
   assign st_major   = st_major_x ? e_adx : e_ady;
   assign st_minor   = st_major_x ? e_ady : e_adx;
   assign st_minor2  = {2'b00, st_minor, 1'b0};
   assign st_major2  = {2'b00, st_major, 1'b0};
   assign st_major1  = {3'b000, st_major};

   // step: error sign, moves and range test
   assign err_pos = !err_ff[ERR_W-1] && (err_ff != '0);
   assign move_x  = major_x_ff || err_pos;
   assign move_y  = !major_x_ff || err_pos;
   assign step_x  = sx_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
   assign step_y  = sy_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
   assign cy_ext  = {{(CMP_W-COORD_BITS){cur_y_ff[COORD_BITS-1]}}, cur_y_ff};
   assign h_ext   = {{(CMP_W-HEIGHT_W){1'b0}}, screen_height};
   assign y_in_range = (cy_ext > 0) && (cy_ext < h_ext);

   // next state and next result
   always_comb begin
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      err_in          = err_ff;
      inc_diag_in     = inc_diag_ff;
      inc_straight_in = inc_straight_ff;
      sx_neg_in       = sx_neg_ff;
      sy_neg_in       = sy_neg_ff;
      major_x_in      = major_x_ff;
      left_in         = left_ff;
      tag_a_in        = tag_a_ff;
      tag_b_in        = tag_b_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      has_point_in  = has_point_ff;
      point_x_in    = point_x_ff;
      point_y_in    = point_y_ff;
      in_range_in   = in_range_ff;
      is_last_in    = is_last_ff;
      out_tag_a_in  = out_tag_a_ff;
      out_tag_b_in  = out_tag_b_ff;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
         has_point_in = 1'b0;
         point_x_in   = '0;
         point_y_in   = '0;
         in_range_in  = 1'b0;
         is_last_in   = 1'b0;
         out_tag_a_in = '0;
         out_tag_b_in = '0;
         case (e_action)
            ACT_START: begin
               cur_x_in        = e_x0;
               cur_y_in        = e_y0;
               sx_neg_in       = e_sx_neg;
               sy_neg_in       = e_sy_neg;
               major_x_in      = st_major_x;
               inc_straight_in = st_minor2;
               inc_diag_in     = st_minor2 - st_major2;
               err_in          = st_minor2 - st_major1;
               left_in         = st_major;
               tag_a_in        = e_tag_a;
               tag_b_in        = e_tag_b;
            end
            ACT_STEP: begin
               if (left_ff != '0) begin
                  has_point_in = 1'b1;
                  point_x_in   = cur_x_ff;
                  point_y_in   = cur_y_ff;
                  in_range_in  = y_in_range;
                  is_last_in   = (left_ff == COORD_BITS'(1));
                  out_tag_a_in = tag_a_ff;
                  out_tag_b_in = tag_b_ff;
                  err_in       = err_ff + (err_pos ? inc_diag_ff : inc_straight_ff);
                  if (move_x) begin
                     cur_x_in = step_x;
                  end
                  if (move_y) begin
                     cur_y_in = step_y;
                  end
                  left_in = left_ff - 1'b1;
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   // edge state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff        <= '0;
         cur_y_ff        <= '0;
         err_ff          <= '0;
         inc_diag_ff     <= '0;
         inc_straight_ff <= '0;
         sx_neg_ff       <= 1'b0;
         sy_neg_ff       <= 1'b0;
         major_x_ff      <= 1'b0;
         left_ff         <= '0;
         tag_a_ff        <= '0;
         tag_b_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cur_x_ff        <= cur_x_in;
         cur_y_ff        <= cur_y_in;
         err_ff          <= err_in;
         inc_diag_ff     <= inc_diag_in;
         inc_straight_ff <= inc_straight_in;
         sx_neg_ff       <= sx_neg_in;
         sy_neg_ff       <= sy_neg_in;
         major_x_ff      <= major_x_in;
         left_ff         <= left_in;
         tag_a_ff        <= tag_a_in;
         tag_b_ff        <= tag_b_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      has_point_ff <= has_point_in;
      point_x_ff   <= point_x_in;
      point_y_ff   <= point_y_in;
      in_range_ff  <= in_range_in;
      is_last_ff   <= is_last_in;
      out_tag_a_ff <= out_tag_a_in;
      out_tag_b_ff <= out_tag_b_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_has_point = has_point_ff;
   assign rsp_point_x   = point_x_ff;
   assign rsp_point_y   = point_y_ff;
   assign rsp_in_range  = in_range_ff;
   assign rsp_is_last   = is_last_ff;
   assign rsp_tag_a     = out_tag_a_ff;
   assign rsp_tag_b     = out_tag_b_ff;

   // a word without a point carries nothing else
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_point) |->
         (rsp_point_x == '0) && (rsp_point_y == '0) && !rsp_in_range && !rsp_is_last &&
         (rsp_tag_a == '0) && (rsp_tag_b == '0))
      else $error("empty result word carries data");

   // a last point leaves the edge exhausted
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && e_action == ACT_STEP && left_ff == COORD_BITS'(1)) |=> (left_ff == '0))
      else $error("edge not exhausted after last point");

   // in range only for points strictly above row zero
   a_range_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_range) |-> (rsp_has_point && rsp_point_y > 0))
      else $error("in-range flag on a row at or below zero");

endmodule

`default_nettype wire

// ===== src/line_edge_point_stepper.sv =====
// line_edge_point_stepper: top level of the bresenham edge stepper
// depends on lesp_pkg, lesp_front, lesp_fifo, lesp_back
//
//   port group | direction | handshake          | contents
//   req_       | in        | req_valid/req_stall| action, endpoints, vertex tags
//   rsp_       | out       | rsp_valid/rsp_stall| point, range flag, last flag, tags
//   csr_       | in        | csr_valid/csr_ready| screen height
//
// one word per cycle sustained while rsp_stall is low; each word is registered in a queue slot
// and then passes through the single add-and-compare step into the result register
// the two-slot queue lets the request side keep flowing while a result is stalled
// synchronous active-high reset clears the edge (no points left) and the height to 480
// csr writes are always taken and belong to idle periods
`timescale 1ns / 1ps
`default_nettype none

module line_edge_point_stepper
   import lesp_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int TAG_BITS   = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic                         req_action,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic        [TAG_BITS-1:0]   req_first_tag,
   input  wire logic        [TAG_BITS-1:0]   req_second_tag,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic                         rsp_has_point,
   output      logic signed [COORD_BITS-1:0] rsp_point_x,
   output      logic signed [COORD_BITS-1:0] rsp_point_y,
   output      logic                         rsp_in_range,
   output      logic                         rsp_is_last,
   output      logic        [TAG_BITS-1:0]   rsp_tag_a,
   output      logic        [TAG_BITS-1:0]   rsp_tag_b,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic        [HEIGHT_W-1:0]   csr_screen_height
);

   localparam int ENTRY_W = 3 + 4 * COORD_BITS + 2 * TAG_BITS;

   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [ENTRY_W-1:0]  push_word;
   logic [ENTRY_W-1:0]  head_word;
   lesp_qstat_type      q_stat;
   logic                q_pop;

   // height register
   assign csr_ready = 1'b1;
   assign height_in = (csr_valid && csr_ready) ? csr_screen_height : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RESET;
      end else begin
         height_ff <= height_in;
      end
   end

   // request side stalls only on a full queue
   assign req_stall = q_stat.full;

   lesp_front #(
      .COORD_BITS (COORD_BITS),
      .TAG_BITS   (TAG_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .req_action     (req_action),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_first_tag  (req_first_tag),
      .req_second_tag (req_second_tag),
      .q_data         (push_word)
   );

   lesp_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (push_word),
      .pop       (q_pop),
      .head_data (head_word),
      .stat      (q_stat)
   );

   lesp_back #(
      .COORD_BITS (COORD_BITS),
      .TAG_BITS   (TAG_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_data        (head_word),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .screen_height (height_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_has_point (rsp_has_point),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_in_range  (rsp_in_range),
      .rsp_is_last   (rsp_is_last),
      .rsp_tag_a     (rsp_tag_a),
      .rsp_tag_b     (rsp_tag_b)
   );

endmodule

`default_nettype wire

// ===== tb/line_edge_point_stepper_tb.sv =====
// line_edge_point_stepper_tb: self-checking testbench for the bresenham edge stepper
// depends on lesp_pkg and line_edge_point_stepper; drives random gaps and stalls on both sides
`timescale 1ns / 1ps

module line_edge_point_stepper_tb;
   import lesp_pkg::*;

   localparam int COORD_W = 16;
   localparam int TAG_W   = 16;

   // one request word and one result word as the ports carry them
   typedef struct packed {
      logic        action;
      logic [15:0] sx;
      logic [15:0] sy;
      logic [15:0] ex;
      logic [15:0] ey;
      logic [15:0] tag1;
      logic [15:0] tag2;
   } edge_cmd_type;

   typedef struct packed {
      logic        has_point;
      logic [15:0] px;
      logic [15:0] py;
      logic        in_range;
      logic        is_last;
      logic [15:0] ta;
      logic [15:0] tb;
   } edge_point_type;

   // directed row: when typed is set, want is the result read straight off the behaviour
   typedef struct packed {
      logic           typed;
      edge_cmd_type   cmd;
      edge_point_type want;
   } script_row_type;

   localparam edge_point_type NO_POINT = '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0};
   localparam edge_cmd_type   STEP_CMD = '{ACT_STEP, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                                           16'hFFFF, 16'h0000};
   localparam int N_SCRIPT = 27;

   localparam script_row_type SCRIPT [N_SCRIPT] = '{
      // step straight after reset: nothing active
      '{1'b1, STEP_CMD, NO_POINT},
      // short x-major edge, first point sits on y = 0, then run past its end
      '{1'b1, '{ACT_START, 16'd0, 16'd0, 16'd3, 16'd1, 16'h0001, 16'h0002}, NO_POINT},
      '{1'b1, STEP_CMD, '{1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 16'h0001, 16'h0002}},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b1, STEP_CMD, NO_POINT},
      // zero-length edge emits nothing
      '{1'b1, '{ACT_START, 16'd10, 16'd10, 16'd10, 16'd10, 16'hFFFF, 16'h0000}, NO_POINT},
      '{1'b1, STEP_CMD, NO_POINT},
      // corner to corner, then dropped by a new start the other way round
      '{1'b1, '{ACT_START, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF},
        NO_POINT},
      '{1'b1, STEP_CMD, '{1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF}},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b1, '{ACT_START, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF},
        NO_POINT},
      '{1'b1, STEP_CMD, '{1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'hFFFF}},
      '{1'b0, STEP_CMD, NO_POINT},
      // y-major with x stepping down
      '{1'b1, '{ACT_START, 16'd5, 16'd1, 16'd1, 16'd9, 16'hA5A5, 16'h5A5A}, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      // x-major, x stepping down, y crossing the bottom scan line
      '{1'b1, '{ACT_START, 16'd2, 16'd478, -16'sd4, 16'd481, 16'h1234, 16'h4321}, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      // equal deltas: y is the major axis
      '{1'b1, '{ACT_START, 16'd0, 16'd3, 16'd3, 16'd0, 16'h0007, 16'h0008}, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b0, STEP_CMD, NO_POINT},
      '{1'b1, STEP_CMD, NO_POINT}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_action;
   logic [COORD_W-1:0]  req_start_x;
   logic [COORD_W-1:0]  req_start_y;
   logic [COORD_W-1:0]  req_end_x;
   logic [COORD_W-1:0]  req_end_y;
   logic [TAG_W-1:0]    req_first_tag;
   logic [TAG_W-1:0]    req_second_tag;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_has_point;
   logic [COORD_W-1:0]  rsp_point_x;
   logic [COORD_W-1:0]  rsp_point_y;
   logic                rsp_in_range;
   logic                rsp_is_last;
   logic [TAG_W-1:0]    rsp_tag_a;
   logic [TAG_W-1:0]    rsp_tag_b;
   logic                csr_valid;
   logic                csr_ready;
   logic [HEIGHT_W-1:0] csr_screen_height;

   // edge tracker: its own copy of the stepper state and the height register
   int                  trk_x = 0;
   int                  trk_y = 0;
   int                  trk_err = 0;
   int                  trk_diag = 0;
   int                  trk_straight = 0;
   bit                  trk_xneg = 1'b0;
   bit                  trk_yneg = 1'b0;
   bit                  trk_xmajor = 1'b0;
   int                  trk_left = 0;
   logic [15:0]         trk_tag_a = '0;
   logic [15:0]         trk_tag_b = '0;
   logic [HEIGHT_W-1:0] trk_height = HEIGHT_RESET;

   edge_point_type      pending_points [$];
   int                  fault_count = 0;
   int                  shown_count = 0;
   int                  counted_words = 0;
   bit                  req_steady = 1'b0;
   bit                  rsp_steady = 1'b0;

   line_edge_point_stepper #(
      .COORD_BITS(COORD_W),
      .TAG_BITS  (TAG_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_first_tag    (req_first_tag),
      .req_second_tag   (req_second_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_point    (rsp_has_point),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_in_range     (rsp_in_range),
      .rsp_is_last      (rsp_is_last),
      .rsp_tag_a        (rsp_tag_a),
      .rsp_tag_b        (rsp_tag_b),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_screen_height(csr_screen_height)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #(5_000_000);
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // advance the tracked edge by one word and return the point it gives
   function automatic edge_point_type next_point(input edge_cmd_type c);
      int             x0;
      int             y0;
      int             dx;
      int             dy;
      int             xstep;
      int             ystep;
      edge_point_type pt;
      pt = NO_POINT;
      if (c.action == ACT_START) begin
         x0 = int'($signed(c.sx));
         y0 = int'($signed(c.sy));
         dx = int'($signed(c.ex)) - x0;
         dy = int'($signed(c.ey)) - y0;
         trk_xneg = dx < 0;
         trk_yneg = dy < 0;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         trk_x = x0;
         trk_y = y0;
         trk_tag_a = c.tag1;
         trk_tag_b = c.tag2;
         trk_xmajor = dy < dx;
         if (trk_xmajor) begin
            trk_diag = 2 * (dy - dx);
            trk_straight = 2 * dy;
            trk_err = trk_straight - dx;
            trk_left = dx;
         end else begin
            trk_diag = 2 * (dx - dy);
            trk_straight = 2 * dx;
            trk_err = trk_straight - dy;
            trk_left = dy;
         end
         return pt;
      end
      // exhausted edge: empty result, state kept
      if (trk_left == 0) return pt;
      pt.has_point = 1'b1;
      pt.px = 16'(trk_x);
      pt.py = 16'(trk_y);
      pt.in_range = (trk_y > 0) && (trk_y < int'(trk_height));
      pt.is_last = (trk_left == 1);
      pt.ta = trk_tag_a;
      pt.tb = trk_tag_b;
      xstep = trk_xneg ? -1 : 1;
      ystep = trk_yneg ? -1 : 1;
      // diagonal move when the error is positive, else along the major axis only
      if (trk_err > 0) begin
         if (trk_xmajor) trk_y += ystep;
         else trk_x += xstep;
         trk_err += trk_diag;
      end else begin
         trk_err += trk_straight;
      end
      if (trk_xmajor) trk_x += xstep;
      else trk_y += ystep;
      trk_left--;
      return pt;
   endfunction

   // present one request word after a random gap and hold it until taken
   task automatic send_word(input edge_cmd_type c, input logic typed,
                            input edge_point_type want);
      int             gap;
      edge_point_type pt;
      gap = req_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= c.action;
      req_start_x    <= c.sx;
      req_start_y    <= c.sy;
      req_end_x      <= c.ex;
      req_end_y      <= c.ey;
      req_first_tag  <= c.tag1;
      req_second_tag <= c.tag2;
      do @(posedge clock); while (req_stall);
      pt = next_point(c);
      pending_points.push_back(typed ? want : pt);
      if (c.action == ACT_START || pt.has_point) counted_words++;
   endtask

   // hold the request side idle until every point has come back
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_height(input logic [HEIGHT_W-1:0] h);
      csr_valid         <= 1'b1;
      csr_screen_height <= h;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      trk_height = h;
   endtask

   // one random edge: mostly a start and enough steps to run it out,
   // sometimes a broken sequence, a long edge cut short, or a stray word
   task automatic run_random_edge();
      edge_cmd_type c;
      int           x0;
      int           y0;
      int           ex;
      int           ey;
      int           span;
      int           steps;
      bit           long_edge;
      if ($urandom_range(0, 99) < 8) begin
         c = '{1'($urandom_range(0, 1)), rand16(), rand16(), rand16(), rand16(),
               rand16(), rand16()};
         send_word(c, 1'b0, NO_POINT);
         return;
      end
      if ($urandom_range(0, 11) == 0) req_steady = !req_steady;
      x0 = ($urandom_range(0, 6) == 0) ? int'($signed(rand16()))
                                      : int'($urandom_range(0, 400)) - 200;
      y0 = ($urandom_range(0, 6) == 0) ? int'($signed(rand16()))
                                      : clamp16(int'($urandom_range(0, trk_height + 8)) - 4);
      long_edge = ($urandom_range(0, 19) == 0);
      if (long_edge) begin
         ex = int'($signed(rand16()));
         ey = int'($signed(rand16()));
      end else begin
         ex = clamp16(x0 + int'($urandom_range(0, 48)) - 24);
         ey = clamp16(y0 + int'($urandom_range(0, 48)) - 24);
      end
      span = (ex > x0) ? ex - x0 : x0 - ex;
      if (((ey > y0) ? ey - y0 : y0 - ey) > span) span = (ey > y0) ? ey - y0 : y0 - ey;
      if (long_edge || $urandom_range(0, 4) == 0)
         steps = $urandom_range(0, (span < 40) ? span : 40);
      else
         steps = span + $urandom_range(0, 2);
      c = '{ACT_START, 16'(x0), 16'(y0), 16'(ex), 16'(ey), rand16(), rand16()};
      send_word(c, 1'b0, NO_POINT);
      repeat (steps) begin
         c = '{ACT_STEP, rand16(), rand16(), rand16(), rand16(), rand16(), rand16()};
         send_word(c, 1'b0, NO_POINT);
      end
   endtask

   // result side: random stall before each word, then compare with the oldest expectation
   initial begin
      edge_point_type got;
      edge_point_type want;
      int             gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 59) == 0) rsp_steady = !rsp_steady;
         gap = rsp_steady ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_has_point, rsp_point_x, rsp_point_y, rsp_in_range, rsp_is_last,
                 rsp_tag_a, rsp_tag_b};
         if (pending_points.size() == 0) begin
            fault_count++;
            if (shown_count < 10) begin
               shown_count++;
               $display("%0t: point word with nothing outstanding: pt=%0b x=%0d y=%0d",
                        $time, got.has_point, $signed(got.px), $signed(got.py));
            end
         end else begin
            want = pending_points.pop_front();
            if (got.has_point !== want.has_point || got.px !== want.px ||
                got.py !== want.py || got.in_range !== want.in_range ||
                got.is_last !== want.is_last || got.ta !== want.ta || got.tb !== want.tb) begin
               fault_count++;
               if (shown_count < 10) begin
                  shown_count++;
                  $display("%0t: mismatch expected pt=%0b x=%0d y=%0d rng=%0b last=%0b tags=%h/%h",
                           $time, want.has_point, $signed(want.px), $signed(want.py),
                           want.in_range, want.is_last, want.ta, want.tb);
                  $display("%0t:          actual   pt=%0b x=%0d y=%0d rng=%0b last=%0b tags=%h/%h",
                           $time, got.has_point, $signed(got.px), $signed(got.py),
                           got.in_range, got.is_last, got.ta, got.tb);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [HEIGHT_W-1:0] h;
      int                  target;
      bit                  paused;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= ACT_STEP;
      req_start_x       <= '0;
      req_start_y       <= '0;
      req_end_x         <= '0;
      req_end_y         <= '0;
      req_first_tag     <= '0;
      req_second_tag    <= '0;
      rsp_stall         <= 1'b0;
      csr_valid         <= 1'b0;
      csr_screen_height <= HEIGHT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset height
      for (int i = 0; i < N_SCRIPT; i++)
         send_word(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].want);

      // random phases, each at its own screen height
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: h = '1;
            1: h = HEIGHT_W'(1);
            4: h = HEIGHT_RESET;
            default: h = HEIGHT_W'($urandom_range(1, 32767));
         endcase
         drain_results(4);
         write_height(h);
         target = counted_words + 350;
         paused = 1'b0;
         while (counted_words < target) begin
            // once per phase let the result side empty out completely
            if (!paused && counted_words + 200 >= target) begin
               drain_results(0);
               paused = 1'b1;
            end
            run_random_edge();
         end
      end

      drain_results(10);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
